// ===== hdl/isg_pkg.sv =====
// ----------------------------------------------------------------------------
// isg_pkg
// shared types and constants of the mod-257 image share generator
// ----------------------------------------------------------------------------
package isg_pkg;

  localparam logic [47:0] LCG_MULT   = 48'h0005_DEEC_E66D;
  localparam logic [47:0] LCG_ADD    = 48'd11;
  localparam logic [15:0] RESET_SEED = 16'd691;
  localparam logic [8:0]  FIELD_TOP  = 9'd256;

  // register indexes on the config port
  localparam logic [1:0] REG_THRESHOLD_K = 2'd0;
  localparam logic [1:0] REG_SHARE_COUNT = 2'd1;
  localparam logic [1:0] REG_SEED        = 2'd2;

  typedef struct packed {
    logic [7:0] pixel;
    logic       first;
  } in_t;

  typedef struct packed {
    logic [7:0] share_value;
    logic [4:0] share_number;
    logic       last;
  } out_t;

  // coefficient travelling down the cell row
  typedef struct packed {
    logic       vld;
    logic       start;
    logic [7:0] coef;
  } link_t;

endpackage

// ===== hdl/image_share_generator_mod257_core.sv =====
// a pixel that does not close a section goes through S_LCGA and S_LCGB only; a
// closing pixel then runs evaluation passes (S_EVAL feeds k coefficients, then
// S_DRAIN, S_CHECK; more passes when a share hits 256), then n share items, one
// per cycle unless out_ready stalls; in_ready stays low until the last is loaded
// reset: synchronous, restores config defaults, keystream to the default seed
// ----------------------------------------------------------------------------
// image_share_generator_mod257_core
// whitens pixels with an lcg keystream and emits shamir shares over gf(257)
// ----------------------------------------------------------------------------
module image_share_generator_mod257_core #(
  parameter int MAX_SHARES    = 16,
  parameter int MAX_THRESHOLD = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  isg_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output isg_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import isg_pkg::*;

  localparam int XW  = $clog2(MAX_SHARES + 1);
  localparam int SIW = $clog2(MAX_SHARES);
  localparam int KW  = $clog2(MAX_THRESHOLD + 1);
  localparam int IW  = $clog2(MAX_THRESHOLD);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LCGA  = 7'b0000010,
    S_LCGB  = 7'b0000100,
    S_EVAL  = 7'b0001000,
    S_DRAIN = 7'b0010000,
    S_CHECK = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [4:0]  threshold_k;
  logic [4:0]  share_count;
  logic [15:0] seed;

  logic [KW-1:0] k_eff;
  logic [XW-1:0] n_eff;

  logic [7:0]    pixel;
  logic [7:0]    coefs [MAX_THRESHOLD];
  logic [KW-1:0] fill;
  logic [IW-1:0] fidx;
  logic [KW-1:0] fill_new;
  logic [IW-1:0] feed;
  logic [XW-1:0] drain;
  logic [SIW-1:0] eidx;
  logic          nz_found;
  logic [IW-1:0] nz_idx;
  logic [7:0]    nz_val;
  logic          bad;

  logic          accept;
  logic          cfg_wr;
  logic          out_load;
  logic [7:0]    key;

  link_t         links [MAX_SHARES+1];
  logic [8:0]    accs  [MAX_SHARES];

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_load = (state == S_EMIT) && (!out_valid || out_ready);

  always_comb begin
    if (threshold_k < 5'd2) begin
      k_eff = KW'(2);
    end else if (int'(threshold_k) > MAX_THRESHOLD) begin
      k_eff = KW'(MAX_THRESHOLD);
    end else begin
      k_eff = KW'(threshold_k);
    end
    if (share_count < 5'd2) begin
      n_eff = XW'(2);
    end else if (int'(share_count) > MAX_SHARES) begin
      n_eff = XW'(MAX_SHARES);
    end else begin
      n_eff = XW'(share_count);
    end
  end

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_k <= 5'd2;
      share_count <= 5'd2;
      seed        <= RESET_SEED;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_THRESHOLD_K: threshold_k <= pwdata[4:0];
        REG_SHARE_COUNT: share_count <= pwdata[4:0];
        REG_SEED:        seed        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_THRESHOLD_K: prdata = {27'd0, threshold_k};
      REG_SHARE_COUNT: prdata = {27'd0, share_count};
      REG_SEED:        prdata = {16'd0, seed};
      default:         prdata = 32'd0;
    endcase
  end

  isg_lcg u_lcg (
    .clk     (clk),
    .rst     (rst),
    .reseed  (accept && in_data.first),
    .seed    (seed),
    .step_lo (state == S_LCGA),
    .step_hi (state == S_LCGB),
    .key     (key)
  );

  // cell row, cell j evaluates at x = j + 1
  assign links[0].vld   = (state == S_EVAL);
  assign links[0].start = (KW'(feed) == k_eff - KW'(1));
  assign links[0].coef  = coefs[feed];

  for (genvar j = 0; j < MAX_SHARES; j++) begin : g_cell
    isg_cell #(
      .X  (j + 1),
      .XW (XW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .link_in  (links[j]),
      .link_out (links[j+1]),
      .acc      (accs[j])
    );
  end

  always_comb begin
    bad = 1'b0;
    for (int j = 0; j < MAX_SHARES; j++) begin
      if ((XW'(j) < n_eff) && (accs[j] == FIELD_TOP)) begin
        bad = 1'b1;
      end
    end
  end

  assign fidx     = (fill >= KW'(MAX_THRESHOLD)) ? '0 : fill[IW-1:0];
  assign fill_new = KW'(fidx) + KW'(1);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_LCGA;
      S_LCGA:  state_next = S_LCGB;
      S_LCGB:  state_next = (fill_new >= k_eff) ? S_EVAL : S_IDLE;
      S_EVAL:  if (feed == '0) state_next = S_DRAIN;
      S_DRAIN: if (drain == XW'(MAX_SHARES - 1)) state_next = S_CHECK;
      S_CHECK: state_next = (bad && nz_found) ? S_EVAL : S_EMIT;
      S_EMIT:  if (out_load && (XW'(eidx) + XW'(1) == n_eff)) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      if (accept && in_data.first) begin
        fill <= '0;
      end else if (state == S_LCGB) begin
        fill <= (fill_new >= k_eff) ? '0 : fill_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pixel <= in_data.pixel;
    end
    if (state == S_LCGB) begin
      coefs[fidx] <= pixel ^ key;
    end else if ((state == S_CHECK) && bad && nz_found) begin
      coefs[nz_idx] <= nz_val - 8'd1;
    end
  end

  // feed a(k-1) first, remember the lowest non-zero coefficient on the way
  always_ff @(posedge clk) begin
    if ((state == S_LCGB) || (state == S_CHECK)) begin
      feed     <= IW'(k_eff - KW'(1));
      nz_found <= 1'b0;
    end else if (state == S_EVAL) begin
      if (feed != '0) begin
        feed <= feed - IW'(1);
      end
      if (coefs[feed] != 8'd0) begin
        nz_found <= 1'b1;
        nz_idx   <= feed;
        nz_val   <= coefs[feed];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EVAL) begin
      drain <= '0;
    end else if (state == S_DRAIN) begin
      drain <= drain + XW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CHECK) begin
      eidx <= '0;
    end else if (out_load) begin
      eidx <= eidx + SIW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.share_value  <= accs[eidx][7:0];
      out_data.share_number <= 5'(XW'(eidx) + XW'(1));
      out_data.last         <= (XW'(eidx) + XW'(1) == n_eff);
    end
  end

endmodule

// ===== hdl/isg_lcg.sv =====
// ----------------------------------------------------------------------------
// isg_lcg
// 48-bit linear congruential keystream, multiply split into low and high steps
// ----------------------------------------------------------------------------
module isg_lcg (
  input  logic        clk,
  input  logic        rst,
  input  logic        reseed,
  input  logic [15:0] seed,
  input  logic        step_lo,
  input  logic        step_hi,
  output logic [7:0]  key
);
  import isg_pkg::*;

  localparam logic [16:0] MULT_LO = LCG_MULT[16:0];
  localparam logic [17:0] MULT_HI = LCG_MULT[34:17];

  logic [47:0] gen;
  logic [47:0] p_lo;
  logic [47:0] p_lo_next;
  logic [30:0] p_hi;
  logic [47:0] gen_next;

  assign p_lo_next = gen * {31'd0, MULT_LO};
  assign p_hi      = gen[30:0] * {13'd0, MULT_HI};
  assign gen_next  = p_lo + {p_hi, 17'd0} + LCG_ADD;

  // byte of the advanced state, valid while step_hi is high
  assign key = gen_next[47:40];

  always_ff @(posedge clk) begin
    if (step_lo) begin
      p_lo <= p_lo_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen <= {32'd0, RESET_SEED} ^ LCG_MULT;
    end else if (reseed) begin
      gen <= {32'd0, seed} ^ LCG_MULT;
    end else if (step_hi) begin
      gen <= gen_next;
    end
  end

endmodule

// ===== hdl/isg_cell.sv =====
// ----------------------------------------------------------------------------
// isg_cell
// one horner step mod 257 at a fixed point x, passes the coefficient on
// ----------------------------------------------------------------------------
module isg_cell #(
  parameter int X  = 1,
  parameter int XW = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  isg_pkg::link_t      link_in,
  output isg_pkg::link_t      link_out,
  output logic [8:0]          acc
);
  import isg_pkg::*;

  localparam int PW = 10 + XW;

  logic [PW-1:0] v;
  logic [PW-1:0] hi;
  logic [PW-1:0] lo;
  logic [PW-1:0] res;

  always_comb begin
    v = (link_in.start ? '0 : PW'(acc) * PW'(X)) + PW'(link_in.coef);
    hi = v >> 8;
    lo = PW'(v[7:0]);
    // 256 == -1 mod 257
    if (lo >= hi) begin
      res = lo - hi;
    end else begin
      res = lo + PW'(257) - hi;
    end
  end

  always_ff @(posedge clk) begin
    if (link_in.vld) begin
      acc <= res[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_out.vld <= 1'b0;
    end else begin
      link_out.vld <= link_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    link_out.start <= link_in.start;
    link_out.coef  <= link_in.coef;
  end

endmodule

// ===== dv/image_share_generator_mod257_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// image_share_generator_mod257_core_tb
// drives pixel sections through the share generator under random
// flow control and compares every share item against a built-in predictor
// ----------------------------------------------------------------------------
module image_share_generator_mod257_core_tb;
  import isg_pkg::*;

  localparam int MAXN = 16;
  localparam int MAXK = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [47:0] LCG_MASK = 48'hFFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  image_share_generator_mod257_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [4:0]  cur_k = 5'd2;
  logic [4:0]  cur_n = 5'd2;
  logic [15:0] cur_seed = RESET_SEED;
  logic [47:0] lcg_state = (48'(RESET_SEED) ^ LCG_MULT) & LCG_MASK;
  logic [7:0]  coefs [MAXK];
  int          fill = 0;

  in_t  pixel_queue[$];
  out_t share_queue[$];

  int mismatches = 0;
  int shares_seen = 0;
  int pixels_sent = 0;
  int retry_sections = 0;
  bit long_hold = 1'b0;
  bit done = 1'b0;
  bit in_acc = 1'b0;

  function automatic int eval_poly(int x, int k);
    int acc;
    acc = 0;
    for (int r = k - 1; r >= 0; r--) acc = (acc * x + coefs[r]) % 257;
    return acc;
  endfunction

  task automatic predict_shares(in_t it);
    int k;
    int n;
    int vals[MAXN];
    bit bad;
    int i;
    out_t o;
    k = (cur_k < 2) ? 2 : (cur_k > MAXK) ? MAXK : cur_k;
    n = (cur_n < 2) ? 2 : (cur_n > MAXN) ? MAXN : cur_n;
    if (it.first) begin
      lcg_state = (48'(cur_seed) ^ LCG_MULT) & LCG_MASK;
      fill = 0;
    end
    if (fill >= MAXK) fill = 0;
    lcg_state = (lcg_state * LCG_MULT + LCG_ADD) & LCG_MASK;
    coefs[fill] = it.pixel ^ lcg_state[47:40];
    fill++;
    if (fill < k) return;
    fill = 0;
    forever begin
      bad = 1'b0;
      for (int x = 1; x <= n; x++) begin
        vals[x-1] = eval_poly(x, k);
        if (vals[x-1] == 256) bad = 1'b1;
      end
      if (!bad) break;
      retry_sections++;
      i = 0;
      while (i < k && coefs[i] == 0) i++;
      if (i >= k) break;
      coefs[i]--;
    end
    for (int x = 1; x <= n; x++) begin
      o.share_value = vals[x-1][7:0];
      o.share_number = 5'(x);
      o.last = (x == n);
      share_queue.push_back(o);
    end
  endtask

  // driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_acc) begin
        // hold item
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pixel_queue.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pixel_queue.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, plus one long hold-off
  int hold_cnt = 0;
  always @(negedge clk) begin
    if (long_hold && hold_cnt < 400) begin
      out_ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      case ($urandom_range(0, 3))
        0: out_ready <= 1'b0;
        default: out_ready <= 1'b1;
      endcase
    end
  end

  // monitor
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst) begin
      in_acc <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        predict_shares(in_data);
        pixels_sent++;
      end
      if (out_valid && out_ready) begin
        shares_seen++;
        if (share_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected share item %p", out_data);
        end else begin
          out_t exp_o;
          exp_o = share_queue.pop_front();
          if (exp_o.share_value !== out_data.share_value ||
              exp_o.share_number !== out_data.share_number ||
              exp_o.last !== out_data.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("share mismatch: expected %p got %p", exp_o, out_data);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !done) begin
        $display("watchdog: no progress, %0d share items outstanding",
                 share_queue.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_THRESHOLD_K: cur_k = val[4:0];
      REG_SHARE_COUNT: cur_n = val[4:0];
      default: cur_seed = val[15:0];
    endcase
  endtask

  task automatic wait_idle();
    while (pixel_queue.size() > 0 || in_valid || share_queue.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic push_section(int len, bit start_image);
    in_t it;
    for (int i = 0; i < len; i++) begin
      it.pixel = $urandom_range(0, 255);
      it.first = (i == 0) && start_image;
      pixel_queue.push_back(it);
    end
  endtask

  task automatic random_phase(int count);
    in_t it;
    for (int i = 0; i < count; i++) begin
      it.pixel = $urandom_range(0, 255);
      it.first = ($urandom_range(0, 15) == 0);
      pixel_queue.push_back(it);
    end
  endtask

  initial begin
    in_t it;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: default k=2 n=2, pixel extremes, first on and off
    it.pixel = 8'h00; it.first = 1'b1; pixel_queue.push_back(it);
    it.pixel = 8'hFF; it.first = 1'b0; pixel_queue.push_back(it);
    it.pixel = 8'hFF; it.first = 1'b1; pixel_queue.push_back(it);
    it.pixel = 8'h00; it.first = 1'b0; pixel_queue.push_back(it);
    it.pixel = 8'hAA; it.first = 1'b0; pixel_queue.push_back(it);
    // partial section dropped by the next first item
    it.pixel = 8'h55; it.first = 1'b1; pixel_queue.push_back(it);
    it.pixel = 8'h01; it.first = 1'b0; pixel_queue.push_back(it);
    wait_idle();

    // out-of-range settings clamp: k=0, n=31, seed extremes
    reg_write(REG_THRESHOLD_K, 32'd0);
    reg_write(REG_SHARE_COUNT, 32'd31);
    reg_write(REG_SEED, 32'hFFFF);
    push_section(4, 1'b1);
    wait_idle();
    // threshold above share count, k=16 n=2
    reg_write(REG_THRESHOLD_K, 32'd16);
    reg_write(REG_SHARE_COUNT, 32'd1);
    reg_write(REG_SEED, 32'd0);
    push_section(16, 1'b1);
    wait_idle();

    // random phases over a few settings, long receiver hold in one
    for (int ph = 0; ph < 4; ph++) begin
      reg_write(REG_THRESHOLD_K, $urandom_range(0, 31));
      reg_write(REG_SHARE_COUNT, $urandom_range(0, 31));
      reg_write(REG_SEED, $urandom_range(0, 65535));
      if (ph == 1) long_hold = 1'b1;
      random_phase(25);
      wait_idle();
    end
    // k=16 n=16, well-formed image
    reg_write(REG_THRESHOLD_K, 32'd16);
    reg_write(REG_SHARE_COUNT, 32'd16);
    push_section(32, 1'b1);
    wait_idle();

    done = 1'b1;
    $display("covered %0d pixels, %0d share items, %0d retry passes",
             pixels_sent, shares_seen, retry_sections);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
